@@ rtl/core/bpd_pkg.sv @@
// Blank page detector package: widths, luminance weights, register map,
// sequencer states and the command/status structs of the shared multiplier.
// No dependencies.
package bpd_pkg;

    localparam int MAX_PIXELS_LOG2 = 24;
    localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
    localparam logic [CNT_W-1:0] PIX_LIMIT = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};

    localparam int CH_W       = 8;
    localparam int WT_W       = 16;
    localparam int LUMA_W     = 16;
    localparam int LUMA_SHIFT = 8;
    localparam logic [WT_W-1:0] WT_RED   = 16'd13933;
    localparam logic [WT_W-1:0] WT_GREEN = 16'd46871;
    localparam logic [WT_W-1:0] WT_BLUE  = 16'd4732;

    localparam int SUM_W = 40;
    localparam int SQS_W = 56;
    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd1536;

    localparam int TN_W  = THR_W + CNT_W;
    localparam int ACC_W = 2 * TN_W;
    localparam int MPL_W = TN_W;

    localparam int S_DATA_W = 3 * CH_W;
    localparam int M_DATA_W = 32;
    localparam int M_PAD_W  = M_DATA_W - CNT_W - 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_THRESHOLD = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_GREEN,
        ST_BLUE,
        ST_SQUARE,
        ST_LHS,
        ST_THRN,
        ST_SUMSQ,
        ST_TNSQ
    } bpd_state_t;

    typedef struct packed {
        logic             load;
        logic             keep_acc;
        logic [ACC_W-1:0] acc_init;
        logic [ACC_W-1:0] mcand;
        logic [MPL_W-1:0] mplier;
    } mul_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [ACC_W-1:0] acc;
    } mul_stat_t;

endpackage

@@ rtl/core/bpd_mul.sv @@
// Shared shift-add multiply-accumulate unit, one multiplier bit per cycle.
// Depends on bpd_pkg.
module bpd_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpd_pkg::mul_cmd_t   cmd,
    output bpd_pkg::mul_stat_t  stat
);

    logic [bpd_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [bpd_pkg::ACC_W-1:0] mcand_reg, mcand_next;
    logic [bpd_pkg::MPL_W-1:0] mplier_reg, mplier_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (cmd.load) begin
            acc_next    = cmd.keep_acc ? acc_reg : cmd.acc_init;
            mcand_next  = cmd.mcand;
            mplier_next = cmd.mplier;
        end else if (mplier_reg != '0) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mplier_reg <= '0;
        end else begin
            mplier_reg <= mplier_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign stat.busy = (mplier_reg != '0);
    assign stat.acc  = acc_reg;

endmodule

@@ rtl/core/bpd_ctrl.sv @@
// Sequencer of the blank page detector: pixel accumulators, the final
// variance test on the shared multiplier, and the result register.
// Depends on bpd_pkg.
module bpd_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpd_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpd_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic [bpd_pkg::THR_W-1:0]       threshold,
    output bpd_pkg::mul_cmd_t               mul_cmd,
    input  bpd_pkg::mul_stat_t              mul_stat
);

    bpd_pkg::bpd_state_t state_reg, state_next;

    logic [bpd_pkg::CH_W-1:0]   green_reg, green_next;
    logic [bpd_pkg::CH_W-1:0]   blue_reg, blue_next;
    logic                       last_reg, last_next;
    logic [bpd_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [bpd_pkg::SQS_W-1:0]  sumsq_reg, sumsq_next;
    logic [bpd_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       ovf_reg, ovf_next;
    logic [bpd_pkg::ACC_W-1:0]  lhs_reg, lhs_next;
    logic [bpd_pkg::TN_W-1:0]   tn_reg, tn_next;
    logic                       m_valid_reg, m_valid_next;
    logic [bpd_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                       at_limit;
    logic                       out_free;
    logic [bpd_pkg::LUMA_W-1:0] luma;

    assign at_limit = (count_reg == bpd_pkg::PIX_LIMIT);
    assign out_free = !m_valid_reg || m_tready;
    assign luma     = mul_stat.acc[bpd_pkg::LUMA_SHIFT +: bpd_pkg::LUMA_W];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (!at_limit) begin
                        state_next = bpd_pkg::ST_RED;
                    end else if (s_tlast) begin
                        state_next = bpd_pkg::ST_LHS;
                    end
                end
            end
            bpd_pkg::ST_RED: begin
                if (!mul_stat.busy) state_next = bpd_pkg::ST_GREEN;
            end
            bpd_pkg::ST_GREEN: begin
                if (!mul_stat.busy) state_next = bpd_pkg::ST_BLUE;
            end
            bpd_pkg::ST_BLUE: begin
                if (!mul_stat.busy) state_next = bpd_pkg::ST_SQUARE;
            end
            bpd_pkg::ST_SQUARE: begin
                if (!mul_stat.busy) begin
                    state_next = last_reg ? bpd_pkg::ST_LHS : bpd_pkg::ST_IDLE;
                end
            end
            bpd_pkg::ST_LHS: begin
                if (!mul_stat.busy) state_next = bpd_pkg::ST_THRN;
            end
            bpd_pkg::ST_THRN: begin
                if (!mul_stat.busy) state_next = bpd_pkg::ST_SUMSQ;
            end
            bpd_pkg::ST_SUMSQ: begin
                if (!mul_stat.busy) state_next = bpd_pkg::ST_TNSQ;
            end
            bpd_pkg::ST_TNSQ: begin
                if (!mul_stat.busy && out_free) state_next = bpd_pkg::ST_IDLE;
            end
            default: state_next = bpd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == bpd_pkg::ST_IDLE);
        mul_cmd      = '0;
        green_next   = green_reg;
        blue_next    = blue_reg;
        last_next    = last_reg;
        sum_next     = sum_reg;
        sumsq_next   = sumsq_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        lhs_next     = lhs_reg;
        tn_next      = tn_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            bpd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    green_next = s_tdata[bpd_pkg::CH_W +: bpd_pkg::CH_W];
                    blue_next  = s_tdata[2*bpd_pkg::CH_W +: bpd_pkg::CH_W];
                    last_next  = s_tlast;
                    if (!at_limit) begin
                        mul_cmd.load   = 1'b1;
                        mul_cmd.mcand  = bpd_pkg::ACC_W'(bpd_pkg::WT_RED);
                        mul_cmd.mplier = bpd_pkg::MPL_W'(s_tdata[bpd_pkg::CH_W-1:0]);
                    end else begin
                        ovf_next = 1'b1;
                        if (s_tlast) begin
                            mul_cmd.load   = 1'b1;
                            mul_cmd.mcand  = bpd_pkg::ACC_W'(sumsq_reg);
                            mul_cmd.mplier = bpd_pkg::MPL_W'(count_reg);
                        end
                    end
                end
            end
            bpd_pkg::ST_RED: begin
                if (!mul_stat.busy) begin
                    mul_cmd.load     = 1'b1;
                    mul_cmd.keep_acc = 1'b1;
                    mul_cmd.mcand    = bpd_pkg::ACC_W'(bpd_pkg::WT_GREEN);
                    mul_cmd.mplier   = bpd_pkg::MPL_W'(green_reg);
                end
            end
            bpd_pkg::ST_GREEN: begin
                if (!mul_stat.busy) begin
                    mul_cmd.load     = 1'b1;
                    mul_cmd.keep_acc = 1'b1;
                    mul_cmd.mcand    = bpd_pkg::ACC_W'(bpd_pkg::WT_BLUE);
                    mul_cmd.mplier   = bpd_pkg::MPL_W'(blue_reg);
                end
            end
            bpd_pkg::ST_BLUE: begin
                if (!mul_stat.busy) begin
                    mul_cmd.load     = 1'b1;
                    mul_cmd.acc_init = bpd_pkg::ACC_W'(sumsq_reg);
                    mul_cmd.mcand    = bpd_pkg::ACC_W'(luma);
                    mul_cmd.mplier   = bpd_pkg::MPL_W'(luma);
                    sum_next         = sum_reg + bpd_pkg::SUM_W'(luma);
                    count_next       = count_reg + bpd_pkg::CNT_W'(1);
                end
            end
            bpd_pkg::ST_SQUARE: begin
                if (!mul_stat.busy) begin
                    sumsq_next = mul_stat.acc[bpd_pkg::SQS_W-1:0];
                    if (last_reg) begin
                        mul_cmd.load   = 1'b1;
                        mul_cmd.mcand  = bpd_pkg::ACC_W'(mul_stat.acc[bpd_pkg::SQS_W-1:0]);
                        mul_cmd.mplier = bpd_pkg::MPL_W'(count_reg);
                    end
                end
            end
            bpd_pkg::ST_LHS: begin
                if (!mul_stat.busy) begin
                    lhs_next       = mul_stat.acc;
                    mul_cmd.load   = 1'b1;
                    mul_cmd.mcand  = bpd_pkg::ACC_W'(count_reg);
                    mul_cmd.mplier = bpd_pkg::MPL_W'(threshold);
                end
            end
            bpd_pkg::ST_THRN: begin
                if (!mul_stat.busy) begin
                    tn_next        = mul_stat.acc[bpd_pkg::TN_W-1:0];
                    mul_cmd.load   = 1'b1;
                    mul_cmd.mcand  = bpd_pkg::ACC_W'(sum_reg);
                    mul_cmd.mplier = bpd_pkg::MPL_W'(sum_reg);
                end
            end
            bpd_pkg::ST_SUMSQ: begin
                if (!mul_stat.busy) begin
                    mul_cmd.load     = 1'b1;
                    mul_cmd.keep_acc = 1'b1;
                    mul_cmd.mcand    = bpd_pkg::ACC_W'(tn_reg);
                    mul_cmd.mplier   = tn_reg;
                end
            end
            bpd_pkg::ST_TNSQ: begin
                if (!mul_stat.busy && out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{bpd_pkg::M_PAD_W{1'b0}}, ovf_reg, count_reg,
                                    (lhs_reg <= mul_stat.acc)};
                    sum_next     = '0;
                    sumsq_next   = '0;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bpd_pkg::ST_IDLE;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            sumsq_reg   <= sumsq_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        last_reg   <= last_next;
        lhs_reg    <= lhs_next;
        tn_reg     <= tn_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/core/blank_page_detector_top.sv @@
// Blank page detector top level: APB threshold register, sequencer and
// shared shift-add multiplier. Depends on bpd_pkg, bpd_mul, bpd_ctrl.
// Per pixel, luminance and its square go through the shared shift-add
// unit, one multiplier bit per cycle. A pixel marked last then runs the
// final variance test on the same unit and may wait while an earlier
// result is still held.
// A finished result waits in an output register while the next pixel enters.
// Synchronous active-low reset clears accumulators, sequencer and result valid;
// threshold resets to 6.00.
module blank_page_detector_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bpd_pkg::S_DATA_W-1:0]      s_tdata,   // red, green, blue
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpd_pkg::M_DATA_W-1:0]      m_tdata,   // is_blank, pixels_seen, count_overflow
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bpd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [bpd_pkg::THR_W-1:0] thr_reg, thr_next;
    logic                      sel_thr;
    bpd_pkg::mul_cmd_t         mul_cmd;
    bpd_pkg::mul_stat_t        mul_stat;

    assign pready  = 1'b1;
    assign sel_thr = (paddr[bpd_pkg::APB_ADDR_W-1:2] == bpd_pkg::REG_IDX_THRESHOLD);
    assign prdata  = sel_thr ? bpd_pkg::APB_DATA_W'(thr_reg) : '0;

    always_comb begin
        thr_next = thr_reg;
        if (psel && penable && pwrite && pready && sel_thr) begin
            thr_next = pwdata[bpd_pkg::THR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= bpd_pkg::THR_RESET;
        end else begin
            thr_reg <= thr_next;
        end
    end

    bpd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .stat    (mul_stat)
    );

    bpd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .threshold (thr_reg),
        .mul_cmd   (mul_cmd),
        .mul_stat  (mul_stat)
    );

`ifndef SYNTH
    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result posted while sequencer busy");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[bpd_pkg::CNT_W:1] != '0))
        else $error("result with zero pixel count");

    a_overflow_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[bpd_pkg::CNT_W+1]) |->
        (m_tdata[bpd_pkg::CNT_W:1] == bpd_pkg::PIX_LIMIT))
        else $error("overflow flagged below pixel limit");
`endif

endmodule
